[hw/rtl/brff_pkg.sv]
// brff_pkg: shared widths, codes and types for the background rectangle fit/fill block.
// No dependencies; imported by every module under hw/rtl.
package brff_pkg;

  // Dimension and scale widths
  localparam int DIM_BITS        = 16;
  localparam int SCALE_FRAC_BITS = 16;
  localparam int QUO_BITS        = DIM_BITS + SCALE_FRAC_BITS;  // scale word
  localparam int DIV_STEPS       = QUO_BITS;                    // one quotient bit per stage
  localparam int SUBPIX_BITS     = 4;                           // 1/16 pixel
  localparam int SCALE_SHIFT     = SCALE_FRAC_BITS - SUBPIX_BITS;
  localparam int PROD_BITS       = DIM_BITS + QUO_BITS;
  localparam int EXT_BITS        = PROD_BITS + 28;

  // Result widths
  localparam int SIZE_BITS = 28;
  localparam int POS_BITS  = 30;
  localparam int PW        = POS_BITS + 1;

  localparam logic [SIZE_BITS-1:0] SIZE_MAX  = '1;
  localparam logic [QUO_BITS-1:0]  SCALE_ONE = QUO_BITS'(64'd1 << SCALE_FRAC_BITS);

  // Edge offsets: 16*stage*5/100 = stage*4/5, 16*stage*95/100 = stage*76/5
  localparam int EDGE_NEAR_NUM = 4;
  localparam int EDGE_FAR_NUM  = 76;
  localparam int X_BITS        = DIM_BITS + 7;
  localparam int RECIP_SHIFT   = DIM_BITS + 9;
  localparam int RECIP_BITS    = RECIP_SHIFT - 2;
  localparam logic [RECIP_BITS-1:0] RECIP5 =
    RECIP_BITS'(((64'd1 << RECIP_SHIFT) / 64'd5) + 64'd1);
  localparam int RPROD_BITS    = X_BITS + RECIP_BITS;
  localparam int EDGE_BITS     = RPROD_BITS - RECIP_SHIFT;

  // Ports
  localparam int MODE_BITS    = 2;
  localparam int GRAV_BITS    = 4;
  localparam int CFG_IDX_BITS = 2;

  // Configuration register indexes and reset values
  localparam logic [CFG_IDX_BITS-1:0] REG_STAGE_WIDTH  = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_STAGE_HEIGHT = CFG_IDX_BITS'(1);
  localparam logic [DIM_BITS-1:0]     STAGE_W_RESET    = DIM_BITS'(1920);
  localparam logic [DIM_BITS-1:0]     STAGE_H_RESET    = DIM_BITS'(1080);

  // Gravity codes
  localparam logic [GRAV_BITS-1:0] GRAV_CENTRE = 4'd0;
  localparam logic [GRAV_BITS-1:0] GRAV_TOP    = 4'd1;
  localparam logic [GRAV_BITS-1:0] GRAV_BOTTOM = 4'd2;
  localparam logic [GRAV_BITS-1:0] GRAV_LEFT   = 4'd3;
  localparam logic [GRAV_BITS-1:0] GRAV_RIGHT  = 4'd4;
  localparam logic [GRAV_BITS-1:0] GRAV_TL     = 4'd5;
  localparam logic [GRAV_BITS-1:0] GRAV_TR     = 4'd6;
  localparam logic [GRAV_BITS-1:0] GRAV_BL     = 4'd7;
  localparam logic [GRAV_BITS-1:0] GRAV_BR     = 4'd8;

  // Queue between front and back
  localparam int FIFO_DEPTH    = 2;
  localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);

  typedef enum logic [MODE_BITS-1:0] {
    MODE_FILL       = 2'd0,
    MODE_FIT        = 2'd1,
    MODE_FIT_SHRINK = 2'd2,
    MODE_STRETCH    = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    SIDE_CENTRE = 2'd0,
    SIDE_NEAR   = 2'd1,
    SIDE_FAR    = 2'd2
  } side_e;

  // Classified request handed from front to back
  typedef struct packed {
    logic                empty;
    mode_e               mode;
    side_e               hside;
    side_e               vside;
    logic [DIM_BITS-1:0] img_w;
    logic [DIM_BITS-1:0] img_h;
  } job_t;

  // Queue status seen by the front
  typedef struct packed {
    logic full;
    logic valid;
  } fifo_stat_t;

endpackage

[hw/rtl/brff_front.sv]
// brff_front: accepts requests and classifies them (empty check, gravity sides).
// Depends on brff_pkg.
module brff_front import brff_pkg::*; (
  input  logic                 start_i,
  input  logic [DIM_BITS-1:0]  image_width_i,
  input  logic [DIM_BITS-1:0]  image_height_i,
  input  logic [MODE_BITS-1:0] scale_mode_i,
  input  logic [GRAV_BITS-1:0] gravity_i,
  input  fifo_stat_t           fifo_stat_i,
  output logic                 busy_o,
  output logic                 push_o,
  output job_t                 job_o
);

  side_e hside, vside;

  always_comb begin
    unique case (gravity_i) inside
      GRAV_LEFT, GRAV_TL, GRAV_BL:  hside = SIDE_NEAR;
      GRAV_RIGHT, GRAV_TR, GRAV_BR: hside = SIDE_FAR;
      default:                      hside = SIDE_CENTRE;
    endcase
    unique case (gravity_i) inside
      GRAV_TOP, GRAV_TL, GRAV_TR:    vside = SIDE_NEAR;
      GRAV_BOTTOM, GRAV_BL, GRAV_BR: vside = SIDE_FAR;
      default:                       vside = SIDE_CENTRE;
    endcase
  end

  assign busy_o = fifo_stat_i.full;
  assign push_o = start_i && !fifo_stat_i.full;

  assign job_o.empty = (image_width_i == '0) || (image_height_i == '0);
  assign job_o.mode  = mode_e'(scale_mode_i);
  assign job_o.hside = hside;
  assign job_o.vside = vside;
  assign job_o.img_w = image_width_i;
  assign job_o.img_h = image_height_i;

endmodule

[hw/rtl/brff_fifo.sv]
// brff_fifo: short request queue decoupling front and back.
// Depends on brff_pkg (job_t, fifo_stat_t, depth).
module brff_fifo import brff_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  job_t       job_i,
  input  logic       pop_i,
  output fifo_stat_t stat_o,
  output job_t       head_o
);

  job_t                     mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_BITS-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [FIFO_PTR_BITS:0]   count_q, count_d;
  logic                     do_pop;

  assign do_pop = pop_i && (count_q != '0);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push_i && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && do_pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  assign head_o       = mem_q[rd_ptr_q];
  assign stat_o.valid = (count_q != '0);
  assign stat_o.full  = (count_q == (FIFO_PTR_BITS + 1)'(FIFO_DEPTH));

endmodule

[hw/rtl/brff_div.sv]
// brff_div: pipelined restoring divider, one quotient bit per stage.
// Depends on brff_pkg (QUO_BITS, DIM_BITS, DIV_STEPS).
module brff_div import brff_pkg::*; (
  input  logic                clk_i,
  input  logic [QUO_BITS-1:0] dividend_i,
  input  logic [DIM_BITS-1:0] divisor_i,
  output logic [QUO_BITS-1:0] quotient_o
);

  logic [DIM_BITS-1:0] rem_q [DIV_STEPS];
  logic [QUO_BITS-1:0] num_q [DIV_STEPS];
  logic [DIM_BITS-1:0] den_q [DIV_STEPS];

  logic [DIM_BITS-1:0] rem_p [DIV_STEPS];
  logic [QUO_BITS-1:0] num_p [DIV_STEPS];
  logic [DIM_BITS-1:0] den_p [DIV_STEPS];
  logic [DIM_BITS-1:0] rem_d [DIV_STEPS];
  logic [QUO_BITS-1:0] num_d [DIV_STEPS];

  always_comb begin
    logic [DIM_BITS:0] trial;
    logic [DIM_BITS:0] diff;
    rem_p[0] = '0;
    num_p[0] = dividend_i;
    den_p[0] = divisor_i;
    for (int k = 1; k < DIV_STEPS; k++) begin
      rem_p[k] = rem_q[k-1];
      num_p[k] = num_q[k-1];
      den_p[k] = den_q[k-1];
    end
    for (int k = 0; k < DIV_STEPS; k++) begin
      // numerator shifts out at the top, quotient bits shift in at the bottom
      trial = {rem_p[k], num_p[k][QUO_BITS-1]};
      diff  = trial - {1'b0, den_p[k]};
      if (trial >= {1'b0, den_p[k]}) begin
        rem_d[k] = diff[DIM_BITS-1:0];
        num_d[k] = {num_p[k][QUO_BITS-2:0], 1'b1};
      end else begin
        rem_d[k] = trial[DIM_BITS-1:0];
        num_d[k] = {num_p[k][QUO_BITS-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < DIV_STEPS; k++) begin
      rem_q[k] <= rem_d[k];
      num_q[k] <= num_d[k];
      den_q[k] <= den_p[k];
    end
  end

  assign quotient_o = num_q[DIV_STEPS-1];

endmodule

[hw/rtl/brff_back.sv]
// brff_back: scale division, mode select, size multiply, saturation and placement.
// Depends on brff_pkg and brff_div.
module brff_back import brff_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       job_valid_i,
  input  job_t                       job_i,
  input  logic [DIM_BITS-1:0]        stage_w_i,
  input  logic [DIM_BITS-1:0]        stage_h_i,
  output logic                       done_o,
  output logic signed [POS_BITS-1:0] rect_x_o,
  output logic signed [POS_BITS-1:0] rect_y_o,
  output logic [SIZE_BITS-1:0]       rect_width_o,
  output logic [SIZE_BITS-1:0]       rect_height_o,
  output logic                       saturated_o
);

  // Placement of one axis; result is 30-bit two's complement
  function automatic logic [POS_BITS-1:0] place(input side_e side,
                                                input logic [DIM_BITS-1:0] stage,
                                                input logic [EDGE_BITS-1:0] near,
                                                input logic [EDGE_BITS-1:0] far,
                                                input logic [SIZE_BITS-1:0] size);
    logic signed [PW-1:0] s16;
    logic signed [PW-1:0] sz;
    logic signed [PW-1:0] diff;
    s16  = PW'({stage, {SUBPIX_BITS{1'b0}}});
    sz   = PW'(size);
    diff = s16 - sz;
    case (side)
      SIDE_NEAR: return POS_BITS'(near);
      SIDE_FAR:  return POS_BITS'(PW'(far) - sz);
      default:   return diff[POS_BITS:1];  // floor halving
    endcase
  endfunction

  // Scale dividers: (stage << frac) / image
  logic [QUO_BITS-1:0] quo_w, quo_h;

  brff_div u_div_w (
    .clk_i      (clk_i),
    .dividend_i ({stage_w_i, {SCALE_FRAC_BITS{1'b0}}}),
    .divisor_i  (job_i.img_w),
    .quotient_o (quo_w)
  );

  brff_div u_div_h (
    .clk_i      (clk_i),
    .dividend_i ({stage_h_i, {SCALE_FRAC_BITS{1'b0}}}),
    .divisor_i  (job_i.img_h),
    .quotient_o (quo_h)
  );

  // Request fields ride alongside the dividers
  logic [DIV_STEPS-1:0] vld_line_q;
  job_t                 job_line_q [DIV_STEPS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_line_q <= '0;
    end else begin
      vld_line_q <= {vld_line_q[DIV_STEPS-2:0], job_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    job_line_q[0] <= job_i;
    for (int k = 1; k < DIV_STEPS; k++) begin
      job_line_q[k] <= job_line_q[k-1];
    end
  end

  // Edge offsets depend only on the stage registers
  logic [X_BITS-1:0]     w_x4, w_x76, h_x4, h_x76;
  logic [RPROD_BITS-1:0] w_near_pq, w_far_pq, h_near_pq, h_far_pq;
  logic [EDGE_BITS-1:0]  w_near, w_far, h_near, h_far;

  assign w_x4  = X_BITS'(stage_w_i) * X_BITS'(EDGE_NEAR_NUM);
  assign w_x76 = X_BITS'(stage_w_i) * X_BITS'(EDGE_FAR_NUM);
  assign h_x4  = X_BITS'(stage_h_i) * X_BITS'(EDGE_NEAR_NUM);
  assign h_x76 = X_BITS'(stage_h_i) * X_BITS'(EDGE_FAR_NUM);

  always_ff @(posedge clk_i) begin
    w_near_pq <= RPROD_BITS'(w_x4)  * RPROD_BITS'(RECIP5);
    w_far_pq  <= RPROD_BITS'(w_x76) * RPROD_BITS'(RECIP5);
    h_near_pq <= RPROD_BITS'(h_x4)  * RPROD_BITS'(RECIP5);
    h_far_pq  <= RPROD_BITS'(h_x76) * RPROD_BITS'(RECIP5);
  end

  assign w_near = w_near_pq[RPROD_BITS-1:RECIP_SHIFT];
  assign w_far  = w_far_pq[RPROD_BITS-1:RECIP_SHIFT];
  assign h_near = h_near_pq[RPROD_BITS-1:RECIP_SHIFT];
  assign h_far  = h_far_pq[RPROD_BITS-1:RECIP_SHIFT];

  // Stage A: mode select
  job_t                job_a_q;
  logic                vld_a_q;
  logic [QUO_BITS-1:0] sx_q, sy_q, sx_d, sy_d, s_min, s_max;
  job_t                job_z;

  assign job_z = job_line_q[DIV_STEPS-1];
  assign s_min = (quo_w < quo_h) ? quo_w : quo_h;
  assign s_max = (quo_w < quo_h) ? quo_h : quo_w;

  always_comb begin
    case (job_z.mode)
      MODE_FILL: begin
        sx_d = s_max;
        sy_d = s_max;
      end
      MODE_FIT: begin
        sx_d = s_min;
        sy_d = s_min;
      end
      MODE_FIT_SHRINK: begin
        sx_d = (s_min > SCALE_ONE) ? SCALE_ONE : s_min;
        sy_d = sx_d;
      end
      default: begin
        sx_d = quo_w;
        sy_d = quo_h;
      end
    endcase
  end

  // Stage B: size products
  job_t                 job_b_q;
  logic                 vld_b_q;
  logic [PROD_BITS-1:0] prod_w_q, prod_h_q;

  // Stage C: scale down and saturate
  job_t                 job_c_q;
  logic                 vld_c_q;
  logic [SIZE_BITS-1:0] w_c_q, h_c_q;
  logic                 sat_c_q;
  logic [EXT_BITS-1:0]  ext_w, ext_h;
  logic                 sat_w, sat_h;

  assign ext_w = EXT_BITS'(prod_w_q >> SCALE_SHIFT);
  assign ext_h = EXT_BITS'(prod_h_q >> SCALE_SHIFT);
  assign sat_w = ext_w > EXT_BITS'(SIZE_MAX);
  assign sat_h = ext_h > EXT_BITS'(SIZE_MAX);

  // Stage D: placement
  logic                 done_q;
  logic [POS_BITS-1:0]  x_q, y_q;
  logic [SIZE_BITS-1:0] wd_q, hd_q;
  logic                 satd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
      vld_c_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      vld_a_q <= vld_line_q[DIV_STEPS-1];
      vld_b_q <= vld_a_q;
      vld_c_q <= vld_b_q;
      done_q  <= vld_c_q;
    end
  end

  always_ff @(posedge clk_i) begin
    job_a_q  <= job_z;
    sx_q     <= sx_d;
    sy_q     <= sy_d;
    job_b_q  <= job_a_q;
    prod_w_q <= PROD_BITS'(job_a_q.img_w) * PROD_BITS'(sx_q);
    prod_h_q <= PROD_BITS'(job_a_q.img_h) * PROD_BITS'(sy_q);
    job_c_q  <= job_b_q;
    w_c_q    <= sat_w ? SIZE_MAX : ext_w[SIZE_BITS-1:0];
    h_c_q    <= sat_h ? SIZE_MAX : ext_h[SIZE_BITS-1:0];
    sat_c_q  <= sat_w || sat_h;
    if (job_c_q.empty) begin
      x_q    <= '0;
      y_q    <= '0;
      wd_q   <= '0;
      hd_q   <= '0;
      satd_q <= 1'b0;
    end else begin
      x_q    <= place(job_c_q.hside, stage_w_i, w_near, w_far, w_c_q);
      y_q    <= place(job_c_q.vside, stage_h_i, h_near, h_far, h_c_q);
      wd_q   <= w_c_q;
      hd_q   <= h_c_q;
      satd_q <= sat_c_q;
    end
  end

  assign done_o        = done_q;
  assign rect_x_o      = x_q;
  assign rect_y_o      = y_q;
  assign rect_width_o  = wd_q;
  assign rect_height_o = hd_q;
  assign saturated_o   = satd_q;

  // An empty image must come out as an all-zero rectangle
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_c_q && job_c_q.empty |=> done_o && rect_width_o == '0 && rect_height_o == '0
      && rect_x_o == '0 && rect_y_o == '0 && !saturated_o)
    else $error("empty image did not give a zero rectangle");

  // The flag only rises with a clipped size
  a_sat_clip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && saturated_o |-> rect_width_o == SIZE_MAX || rect_height_o == SIZE_MAX)
    else $error("saturated flag without a clipped size");

endmodule

[hw/rtl/background_rect_fit_fill.sv]
// background_rect_fit_fill: top level; stage registers, front, queue and back.
// Depends on brff_pkg, brff_front, brff_fifo, brff_back.
//
// Places a background image on the stage: scales per scale_mode_i (fill, fit, fit without
// enlarging, stretch), sizes in 1/16 pixel with floor rounding and saturation at 2^28-1,
// then positions per gravity_i (edges at 5%/95% of the stage, otherwise centered).
// A request transfers on a clock edge with start_i high and busy_o low. One request can
// transfer every cycle while busy_o is low; a request passes through the request queue,
// the 32-stage restoring divider that forms the Q16.16 scales, then mode select,
// multiply, saturate and placement stages. Each result is shown for exactly one cycle with
// done_o high; there is no backpressure on the result side, so take it when it appears.
// busy_o only rises if the request queue fills, which does not happen in normal operation
// since the back end drains one entry per cycle.
// Stage size registers (index 0 width, 1 height, reset 1920x1080) are written over the
// cfg channel, which is always ready; write them only while no request is in flight.
// A zero image width or height returns an all-zero result.
module background_rect_fit_fill import brff_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // request
  input  logic                       start_i,
  output logic                       busy_o,
  input  logic [DIM_BITS-1:0]        image_width_i,
  input  logic [DIM_BITS-1:0]        image_height_i,
  input  logic [MODE_BITS-1:0]       scale_mode_i,
  input  logic [GRAV_BITS-1:0]       gravity_i,
  // configuration
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [CFG_IDX_BITS-1:0]    cfg_index_i,
  input  logic [DIM_BITS-1:0]        cfg_data_i,
  // result
  output logic                       done_o,
  output logic signed [POS_BITS-1:0] rect_x_o,
  output logic signed [POS_BITS-1:0] rect_y_o,
  output logic [SIZE_BITS-1:0]       rect_width_o,
  output logic [SIZE_BITS-1:0]       rect_height_o,
  output logic                       saturated_o
);

  localparam int PIPE_LAT = DIV_STEPS + 5;  // transfer edge to done_o sampled high
  localparam int BACK_LAT = DIV_STEPS + 4;  // queue head to done_o

  // Stage size registers
  logic [DIM_BITS-1:0] stage_w_q, stage_w_d, stage_h_q, stage_h_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    stage_w_d = stage_w_q;
    stage_h_d = stage_h_q;
    if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_STAGE_WIDTH:  stage_w_d = cfg_data_i;
        REG_STAGE_HEIGHT: stage_h_d = cfg_data_i;
        default:          ;  // unmapped index, write dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_w_q <= STAGE_W_RESET;
      stage_h_q <= STAGE_H_RESET;
    end else begin
      stage_w_q <= stage_w_d;
      stage_h_q <= stage_h_d;
    end
  end

  // Front: transfer and classify
  fifo_stat_t q_stat;
  logic       q_push;
  job_t       q_in, q_head;

  brff_front u_front (
    .start_i        (start_i),
    .image_width_i  (image_width_i),
    .image_height_i (image_height_i),
    .scale_mode_i   (scale_mode_i),
    .gravity_i      (gravity_i),
    .fifo_stat_i    (q_stat),
    .busy_o         (busy_o),
    .push_o         (q_push),
    .job_o          (q_in)
  );

  // Queue: the back end pops whenever an entry is present
  brff_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .job_i  (q_in),
    .pop_i  (q_stat.valid),
    .stat_o (q_stat),
    .head_o (q_head)
  );

  // Back: arithmetic pipeline
  brff_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .job_valid_i   (q_stat.valid),
    .job_i         (q_head),
    .stage_w_i     (stage_w_q),
    .stage_h_i     (stage_h_q),
    .done_o        (done_o),
    .rect_x_o      (rect_x_o),
    .rect_y_o      (rect_y_o),
    .rect_width_o  (rect_width_o),
    .rect_height_o (rect_height_o),
    .saturated_o   (saturated_o)
  );

  // Every accepted request produces its result after the fixed latency
  a_req_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##(PIPE_LAT) done_o)
    else $error("request transfer without result at expected latency");

  // No result without a request having left the queue
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !q_stat.valid |-> ##(BACK_LAT) !done_o)
    else $error("result strobe without a queued request");

endmodule

[verif/tb_top.sv]
// tb_top: self-checking bench for background_rect_fit_fill (stage fit/fill placement).
// Depends on brff_pkg and the background_rect_fit_fill RTL; needs no files or arguments.
// A bit-exact predictor checks every result across several stage sizes and idle patterns.
`timescale 1ns / 100ps

module tb_top;
  import brff_pkg::*;

  // Gravity codes past BR have no name in the package; the block centers them.
  localparam logic [GRAV_BITS-1:0] GRAV_UNKNOWN_LO = 4'd9;
  localparam logic [GRAV_BITS-1:0] GRAV_UNKNOWN_HI = 4'd15;
  // Drain time covers the result pipeline; leave some slack at the end.
  localparam int DRAIN_CYCLES = DIV_STEPS + 5 + 10;
  // Worst run is about 1100 requests at 77% idle plus drains; this is many times that.
  localparam int CYCLE_LIMIT  = 200000;

  typedef struct {
    logic [DIM_BITS-1:0]  iw;
    logic [DIM_BITS-1:0]  ih;
    mode_e                mode;
    logic [GRAV_BITS-1:0] grav;
  } req_t;

  typedef struct {
    logic [POS_BITS-1:0]  x;
    logic [POS_BITS-1:0]  y;
    logic [SIZE_BITS-1:0] w;
    logic [SIZE_BITS-1:0] h;
    logic                 sat;
  } rect_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                       start_i        = 1'b0;
  logic                       busy_o;
  logic [DIM_BITS-1:0]        image_width_i  = '0;
  logic [DIM_BITS-1:0]        image_height_i = '0;
  logic [MODE_BITS-1:0]       scale_mode_i   = '0;
  logic [GRAV_BITS-1:0]       gravity_i      = '0;
  logic                       cfg_valid_i    = 1'b0;
  logic                       cfg_ready_o;
  logic [CFG_IDX_BITS-1:0]    cfg_index_i    = '0;
  logic [DIM_BITS-1:0]        cfg_data_i     = '0;
  logic                       done_o;
  logic signed [POS_BITS-1:0] rect_x_o;
  logic signed [POS_BITS-1:0] rect_y_o;
  logic [SIZE_BITS-1:0]       rect_width_o;
  logic [SIZE_BITS-1:0]       rect_height_o;
  logic                       saturated_o;

  // Bench-side copy of the stage registers, tracks every config transfer.
  logic [DIM_BITS-1:0] stage_w = STAGE_W_RESET;
  logic [DIM_BITS-1:0] stage_h = STAGE_H_RESET;

  req_t  pend_q[$];   // requests waiting to be driven
  rect_t rect_q[$];   // predicted rectangles, oldest first
  rect_t want_r;
  int    idle_pct = 0;
  int    err_cnt  = 0;
  int    cycles   = 0;

  background_rect_fit_fill uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .image_width_i  (image_width_i),
    .image_height_i (image_height_i),
    .scale_mode_i   (scale_mode_i),
    .gravity_i      (gravity_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .done_o         (done_o),
    .rect_x_o       (rect_x_o),
    .rect_y_o       (rect_y_o),
    .rect_width_o   (rect_width_o),
    .rect_height_o  (rect_height_o),
    .saturated_o    (saturated_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Image dimension times Q16.16 scale, in 1/16 px, floored; clips at 2^28-1.
  // Product stays under 2^48, so 64-bit math never wraps.
  function automatic logic [SIZE_BITS-1:0] scale_px(input logic [DIM_BITS-1:0] img,
                                                    input logic [63:0] scale,
                                                    inout logic sat);
    logic [63:0] v;
    v = (64'(img) * scale) >> SCALE_SHIFT;
    if (v > 64'(SIZE_MAX)) begin
      sat = 1'b1;
      return SIZE_MAX;
    end
    return v[SIZE_BITS-1:0];
  endfunction

  // Position on one axis. Near edge at 5% of stage, far edge ends at 95%,
  // centre floors (S - w)/2 toward minus infinity (arithmetic shift).
  function automatic logic [POS_BITS-1:0] place_pos(input logic [DIM_BITS-1:0] stage,
                                                    input logic [SIZE_BITS-1:0] size,
                                                    input side_e side);
    longint s16, sz, p;
    s16 = stage;
    s16 = s16 * 16;
    sz  = size;
    case (side)
      SIDE_NEAR: p = (s16 * 5) / 100;
      SIDE_FAR:  p = (s16 * 95) / 100 - sz;
      default:   p = (s16 - sz) >>> 1;
    endcase
    return p[POS_BITS-1:0];
  endfunction

  function automatic rect_t fit_rect(input logic [DIM_BITS-1:0] iw, ih,
                                     input mode_e mode, input logic [GRAV_BITS-1:0] grav);
    rect_t       r;
    logic [63:0] ws, hs, sx, sy;
    logic        sat;
    side_e       hside, vside;
    r = '{default: '0};
    // Empty image: all-zero rectangle, no scale computed.
    if (iw == '0 || ih == '0) return r;
    // Zero stage just gives a zero scale on that axis.
    ws = (64'(stage_w) << SCALE_FRAC_BITS) / 64'(iw);
    hs = (64'(stage_h) << SCALE_FRAC_BITS) / 64'(ih);
    case (mode)
      MODE_FILL: begin
        sx = (ws > hs) ? ws : hs;
        sy = sx;
      end
      MODE_FIT: begin
        sx = (ws < hs) ? ws : hs;
        sy = sx;
      end
      MODE_FIT_SHRINK: begin
        sx = (ws < hs) ? ws : hs;
        if (sx > 64'(SCALE_ONE)) sx = 64'(SCALE_ONE);
        sy = sx;
      end
      default: begin
        sx = ws;
        sy = hs;
      end
    endcase
    sat = 1'b0;
    r.w = scale_px(iw, sx, sat);
    r.h = scale_px(ih, sy, sat);
    r.sat = sat;
    case (grav)
      GRAV_LEFT, GRAV_TL, GRAV_BL:  hside = SIDE_NEAR;
      GRAV_RIGHT, GRAV_TR, GRAV_BR: hside = SIDE_FAR;
      default:                      hside = SIDE_CENTRE;
    endcase
    case (grav)
      GRAV_TOP, GRAV_TL, GRAV_TR:    vside = SIDE_NEAR;
      GRAV_BOTTOM, GRAV_BL, GRAV_BR: vside = SIDE_FAR;
      default:                       vside = SIDE_CENTRE;
    endcase
    // Positions use the clipped sizes.
    r.x = place_pos(stage_w, r.w, hside);
    r.y = place_pos(stage_h, r.h, vside);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Mix of empty, extreme, full-range and small dimensions.
  function automatic logic [DIM_BITS-1:0] pick_dim();
    int r;
    r = $urandom_range(99);
    if (r < 5)  return '0;
    if (r < 10) return ($urandom_range(1) != 0) ? '1 : DIM_BITS'(1);
    if (r < 40) return DIM_BITS'($urandom_range(65535));
    if (r < 70) return DIM_BITS'($urandom_range(4096, 1));
    return DIM_BITS'($urandom_range(64, 1));
  endfunction

  function automatic req_t random_req();
    req_t q;
    q.iw   = pick_dim();
    q.ih   = pick_dim();
    q.mode = mode_e'($urandom_range(3));
    // Mostly the nine named gravities, sometimes an unknown code.
    if ($urandom_range(99) < 85) q.grav = GRAV_BITS'($urandom_range(GRAV_BR));
    else q.grav = GRAV_BITS'($urandom_range(GRAV_UNKNOWN_HI, GRAV_UNKNOWN_LO));
    return q;
  endfunction

  task automatic add_req(input logic [DIM_BITS-1:0] iw, ih, input mode_e mode,
                         input logic [GRAV_BITS-1:0] grav);
    pend_q.push_back('{iw: iw, ih: ih, mode: mode, grav: grav});
  endtask

  // Block is idle once every request has transferred and every result came back.
  task automatic wait_drained();
    while (pend_q.size() != 0 || rect_q.size() != 0) @(negedge clk_i);
  endtask

  // One config transfer; the bench copy updates on the transfer edge.
  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [DIM_BITS-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == REG_STAGE_WIDTH) stage_w = val;
    else stage_h = val;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_phase(input logic [DIM_BITS-1:0] sw, sh, input int idle, input int n);
    wait_drained();
    write_reg(REG_STAGE_WIDTH, sw);
    write_reg(REG_STAGE_HEIGHT, sh);
    @(posedge clk_i);
    idle_pct = idle;
    repeat (n) pend_q.push_back(random_req());
  endtask

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    err_cnt++;
  endtask

  // ---------------------------------------------------------------------------
  // Driver: presents the queue head at the falling edge unless idling.
  // The head only leaves the queue once it transfers.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (!rst_ni || pend_q.size() == 0 || $urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
    end else begin
      start_i        <= 1'b1;
      image_width_i  <= pend_q[0].iw;
      image_height_i <= pend_q[0].ih;
      scale_mode_i   <= pend_q[0].mode;
      gravity_i      <= pend_q[0].grav;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks each done_o strobe against the oldest prediction, and
  // predicts every request transfer from the pins it saw.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) begin
        if (rect_q.size() == 0) begin
          report_mismatch("result with nothing outstanding");
        end else begin
          want_r = rect_q.pop_front();
          if (rect_x_o !== want_r.x)
            report_mismatch($sformatf("rect_x got %h exp %h", rect_x_o, want_r.x));
          if (rect_y_o !== want_r.y)
            report_mismatch($sformatf("rect_y got %h exp %h", rect_y_o, want_r.y));
          if (rect_width_o !== want_r.w)
            report_mismatch($sformatf("rect_width got %h exp %h", rect_width_o, want_r.w));
          if (rect_height_o !== want_r.h)
            report_mismatch($sformatf("rect_height got %h exp %h", rect_height_o, want_r.h));
          if (saturated_o !== want_r.sat)
            report_mismatch($sformatf("saturated got %b exp %b", saturated_o, want_r.sat));
        end
      end
      if (start_i && !busy_o) begin
        rect_q.push_back(fit_rect(image_width_i, image_height_i,
                                  mode_e'(scale_mode_i), gravity_i));
        void'(pend_q.pop_front());
      end
    end
  end

  // Hard stop in case a result never shows up.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAIL background_rect_fit_fill");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: reset, directed set at the reset stage, then random phases over
  // stage extremes with different idle rates.
  // ---------------------------------------------------------------------------
  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed, stage 1920x1080 from reset, back-to-back transfers.
    idle_pct = 0;
    add_req(16'd0, 16'd1080, MODE_FILL, GRAV_CENTRE);        // empty width
    add_req(16'd1920, 16'd0, MODE_FIT, GRAV_TOP);            // empty height
    add_req(16'd0, 16'd0, MODE_STRETCH, GRAV_BR);            // both empty
    add_req(16'd1920, 16'd1080, MODE_FILL, GRAV_CENTRE);     // exact fit
    add_req(16'd1920, 16'd1080, MODE_FIT, GRAV_TOP);
    add_req(16'd3840, 16'd2160, MODE_FIT_SHRINK, GRAV_BOTTOM);
    add_req(16'd640, 16'd480, MODE_FIT_SHRINK, GRAV_LEFT);   // capped at 1.0
    add_req(16'd640, 16'd480, MODE_FILL, GRAV_RIGHT);
    add_req(16'd640, 16'd480, MODE_FIT, GRAV_TL);
    add_req(16'd640, 16'd480, MODE_STRETCH, GRAV_TR);
    add_req(16'd1, 16'd1, MODE_FILL, GRAV_BL);
    add_req(16'd1, 16'd1, MODE_FIT_SHRINK, GRAV_BR);
    add_req(16'hFFFF, 16'hFFFF, MODE_FILL, GRAV_CENTRE);
    add_req(16'hFFFF, 16'hFFFF, MODE_STRETCH, GRAV_TL);
    add_req(16'd1, 16'hFFFF, MODE_FILL, GRAV_TR);            // height clips
    add_req(16'hFFFF, 16'd1, MODE_FILL, GRAV_BL);            // width clips, far edge < 0
    add_req(16'hFFFF, 16'd1, MODE_FILL, GRAV_BR);
    add_req(16'd1, 16'hFFFF, MODE_FIT, GRAV_RIGHT);
    add_req(16'd4000, 16'd100, MODE_STRETCH, GRAV_BOTTOM);
    add_req(16'd100, 16'd4000, MODE_FIT_SHRINK, GRAV_LEFT);
    add_req(16'd1920, 16'd1080, MODE_FILL, GRAV_UNKNOWN_LO); // unknown gravity
    add_req(16'd1921, 16'd1079, MODE_FIT, GRAV_UNKNOWN_HI);
    add_req(16'd32768, 16'd16384, MODE_FILL, GRAV_TOP);

    // Random phases: stage size, sender idle percent, request count.
    run_phase(16'hFFFF, 16'hFFFF, 0, 130);
    run_phase(16'd1, 16'd1, 77, 130);
    run_phase(16'd1280, 16'd720, 35, 130);
    run_phase(DIM_BITS'($urandom_range(65535, 1)), DIM_BITS'($urandom_range(65535, 1)),
              0, 130);
    run_phase(16'd0, 16'd480, 77, 60);                      // zero stage width
    run_phase(16'hFFFF, 16'd1, 35, 130);
    run_phase(16'd1, 16'hFFFF, 0, 130);
    run_phase(16'd1920, 16'd1080, 77, 130);
    run_phase(DIM_BITS'($urandom_range(4096, 1)), DIM_BITS'($urandom_range(4096, 1)),
              35, 80);

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (err_cnt == 0) begin
      $display("PASS background_rect_fit_fill");
    end else begin
      $display("FAIL background_rect_fit_fill");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/brff_pkg.sv
hw/rtl/brff_front.sv
hw/rtl/brff_fifo.sv
hw/rtl/brff_div.sv
hw/rtl/brff_back.sv
hw/rtl/background_rect_fit_fill.sv
verif/tb_top.sv
